>>> design/request_packet_deframer_defines.svh
// Assertion macros used by the request packet deframer result queue.
`ifndef REQUEST_PACKET_DEFRAMER_DEFINES_SVH
`define REQUEST_PACKET_DEFRAMER_DEFINES_SVH

// Checked on every rising edge of clk_i, disabled while rst_ni is low.
`define RPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset cycles included.
`define RPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/rpd_pkg.sv
// Types and codes shared by the request packet deframer modules.
package rpd_pkg;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_INT    = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LEN_MISMATCH = 2'd1,
    ST_TRUNCATED    = 2'd2,
    ST_UNKNOWN_TYPE = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    PH_LEN   = 8'b0000_0001,
    PH_CMD   = 8'b0000_0010,
    PH_TAG   = 8'b0000_0100,
    PH_TYPE  = 8'b0000_1000,
    PH_COUNT = 8'b0001_0000,
    PH_HEAD  = 8'b0010_0000,
    PH_BODY  = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } phase_e;

  localparam logic [7:0] TYPE_STRING = 8'd1;
  localparam logic [7:0] POS_MAX     = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    kind_e              result_kind;
    logic signed [31:0] value;
    status_e            status;
    logic               end_of_string;
    logic               ends_packet;
  } out_item_t;

  // Results caused by one accepted byte: its own result and the closing status.
  typedef struct packed {
    logic      own_v;
    out_item_t own;
    logic      stat_v;
    out_item_t stat;
  } res_pair_t;

endpackage

>>> design/rpd_parser.sv
// Byte parser: packet state registers and the per-byte next-state and result logic.
module rpd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  rpd_pkg::in_item_t    item_i,
  output rpd_pkg::res_pair_t   res_o
);
  import rpd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  decl_q, decl_d;
  logic        is_str_q, is_str_d;
  logic [7:0]  items_q, items_d;
  logic [7:0]  elem_q, elem_d;
  logic [23:0] acc_q, acc_d;
  logic        fmt_err_q, fmt_err_d;

  logic [7:0]  b;
  logic        mismatch;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    decl_d    = decl_q;
    is_str_d  = is_str_q;
    items_d   = items_q;
    elem_d    = elem_q;
    acc_d     = acc_q;
    fmt_err_d = fmt_err_q;
    mismatch  = 1'b0;
    res_o     = '0;

    unique case (phase_q)
      PH_LEN: begin
        decl_d  = b;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        res_o.own_v             = 1'b1;
        res_o.own.result_kind   = KIND_CMD;
        res_o.own.value         = {24'd0, b};
        phase_d                 = PH_TAG;
      end
      PH_TAG: begin
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        is_str_d  = (b == TYPE_STRING);
        fmt_err_d = (b > TYPE_STRING);
        phase_d   = PH_COUNT;
      end
      PH_COUNT: begin
        items_d = b;
        if (b == 8'd0) begin
          fmt_err_d = 1'b0;
          phase_d   = PH_TAG;
        end else if (fmt_err_q) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_HEAD;
        end
      end
      PH_HEAD: begin
        if (is_str_q) begin
          if (b == 8'd0) begin
            items_d = items_q - 8'd1;
            phase_d = (items_q == 8'd1) ? PH_TAG : PH_HEAD;
          end else begin
            elem_d  = b;
            phase_d = PH_BODY;
          end
        end else begin
          acc_d   = {16'd0, b};
          elem_d  = 8'd3;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (is_str_q) begin
          res_o.own_v               = 1'b1;
          res_o.own.result_kind     = KIND_CHAR;
          res_o.own.value           = {24'd0, b};
          res_o.own.end_of_string   = (elem_q == 8'd1);
          elem_d                    = elem_q - 8'd1;
          if (elem_q == 8'd1) begin
            items_d = items_q - 8'd1;
            phase_d = (items_q == 8'd1) ? PH_TAG : PH_HEAD;
          end
        end else if (elem_q > 8'd1) begin
          acc_d  = {acc_q[15:0], b};
          elem_d = elem_q - 8'd1;
        end else begin
          res_o.own_v           = 1'b1;
          res_o.own.result_kind = KIND_INT;
          res_o.own.value       = {acc_q, b};
          elem_d                = 8'd0;
          items_d               = items_q - 8'd1;
          phase_d               = (items_q == 8'd1) ? PH_TAG : PH_HEAD;
        end
      end
      PH_SKIP: begin
        phase_d = PH_SKIP;
      end
      default: begin
        phase_d = PH_LEN;
      end
    endcase

    if (item_i.last) begin
      // The length check sees a length byte that arrives on this same byte.
      mismatch = (pos_q == POS_MAX) || ({1'b0, pos_q} + 9'd1 != {1'b0, decl_d});
      res_o.stat_v            = 1'b1;
      res_o.stat.result_kind  = KIND_STATUS;
      res_o.stat.ends_packet  = 1'b1;
      if (mismatch) begin
        res_o.stat.status = ST_LEN_MISMATCH;
      end else if (phase_d == PH_SKIP) begin
        res_o.stat.status = ST_UNKNOWN_TYPE;
      end else if (phase_d != PH_TAG) begin
        res_o.stat.status = ST_TRUNCATED;
      end else begin
        res_o.stat.status = ST_OK;
      end
      phase_d   = PH_LEN;
      pos_d     = 8'd0;
      decl_d    = 8'd0;
      is_str_d  = 1'b0;
      items_d   = 8'd0;
      elem_d    = 8'd0;
      acc_d     = 24'd0;
      fmt_err_d = 1'b0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      pos_q     <= 8'd0;
      decl_q    <= 8'd0;
      is_str_q  <= 1'b0;
      items_q   <= 8'd0;
      elem_q    <= 8'd0;
      acc_q     <= 24'd0;
      fmt_err_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      decl_q    <= decl_d;
      is_str_q  <= is_str_d;
      items_q   <= items_d;
      elem_q    <= elem_d;
      acc_q     <= acc_d;
      fmt_err_q <= fmt_err_d;
    end
  end

endmodule

>>> design/rpd_out_queue.sv
// Three-entry result queue: takes up to two results a cycle, hands out one.
`include "request_packet_deframer_defines.svh"

module rpd_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rpd_pkg::res_pair_t   res_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpd_pkg::out_item_t   out_item_o
);
  import rpd_pkg::*;

  localparam int unsigned Depth = 3;

  out_item_t  entry_q [Depth];
  out_item_t  entry_d [Depth];
  logic [1:0] count_q, count_d;
  logic [1:0] cnt_shift;
  logic       pop;
  logic       w0_v, w1_v;
  out_item_t  w0, w1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = entry_q[0];
  // Room for two more results, so the input side never looks at the output ready.
  assign room_o      = (count_q <= 2'd1);

  // Compact the pair: the status moves into the first write when no own result.
  assign w0_v = push_i && (res_i.own_v || res_i.stat_v);
  assign w1_v = push_i && res_i.own_v && res_i.stat_v;
  assign w0   = res_i.own_v ? res_i.own : res_i.stat;
  assign w1   = res_i.stat;

  always_comb begin
    cnt_shift = pop ? count_q - 2'd1 : count_q;
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        entry_d[i] = entry_q[i + 1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if (w0_v && (2'(i) == cnt_shift)) begin
        entry_d[i] = w0;
      end
      if (w1_v && (2'(i) == cnt_shift + 2'd1)) begin
        entry_d[i] = w1;
      end
    end
    count_d = cnt_shift + {1'b0, w0_v} + {1'b0, w1_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  `RPD_ASSERT(a_push_has_room, w0_v |-> (count_q <= 2'd1), "push into a queue without room")
  `RPD_ASSERT(a_full_from_pair, $rose(count_q == 2'd3) |-> $past(w1_v), "queue filled without a pair push")
  `RPD_ASSERT(a_pop_drains, (pop && !w0_v) |=> (count_q == $past(count_q) - 2'd1), "pop did not drain")
  `RPD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (count_q == 2'd0), "queue not empty in reset")

endmodule

>>> design/request_packet_deframer.sv
// Top level of the request packet deframer: byte parser feeding a result queue.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_item_i  (data_byte, last)
//   out       output     out_valid_o / out_ready_i  out_item_o (result_kind, value,
//                                                   status, end_of_string, ends_packet)
//
// One byte is accepted per cycle while the queue has room for two results.
// Each byte yields zero, one or two results; they appear on the output in the
// cycle after acceptance at the earliest, and one per cycle while out_ready_i is high.
// The three-entry result queue sets the rate: with one result per byte and the
// output always ready, bytes flow every cycle; a byte that yields two results
// holds up the next byte until the queue has room for two results again.
// Reset (rst_ni low, asynchronous) returns the parser to waiting for a length byte
// and empties the queue. A stall on the output lets results pile up in the queue;
// in_ready_o drops once it holds two results, and no result is lost.
module request_packet_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpd_pkg::out_item_t  out_item_o
);
  import rpd_pkg::*;

  logic      accept;
  res_pair_t res;

  // The parser state advances only on an accepted item.
  assign accept = in_valid_i && in_ready_o;

  rpd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .res_o    (res)
  );

  // The queue holds the results of accepted items until the consumer takes them.
  rpd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> verif/request_packet_deframer_tb.sv
// Self-checking testbench for the request packet deframer: directed and random frames.
module request_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  // List type codes. Only integer and string lists are known to the parser;
  // every other type byte is an unknown type.
  localparam logic [7:0] TYPE_INTEGER       = 8'd0;
  localparam logic [7:0] TYPE_FIRST_UNKNOWN = 8'd2;
  localparam logic [7:0] TYPE_LAST_UNKNOWN  = 8'hFF;

  // Run limits. The slowest correct run is about 1400 bytes, each waiting out
  // a full sender gap and causing two results that each wait out a full
  // receiver stall. CYCLE_LIMIT stays well above that, so this limit is generous.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int WAIT_MAX     = 18;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 330;
  localparam int HOLD_CYCLES  = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  request_packet_deframer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // Run bookkeeping.
  int errors          = 0;
  int bytes_sent      = 0;
  int frames_sent     = 0;
  int results_checked = 0;
  int cycles_run      = 0;
  int status_count[4] = '{0, 0, 0, 0};

  // Idle control. Each side draws its wait per item from 0 up to its maximum.
  // A nonzero hold_cycles makes the receiver hold off, counting down from that value.
  int tx_wait_max = WAIT_MAX;
  int rx_wait_max = WAIT_MAX;
  int hold_cycles = 0;

  // Bytes of the frame that is about to be sent.
  logic [7:0] frame_bytes[$];

  // Parser state as the block should hold it, and the results that the bytes
  // accepted so far should still produce, oldest first.
  phase_e      frame_phase;
  logic [7:0]  bytes_seen;
  logic [7:0]  length_field;
  logic [7:0]  elements_left;
  logic [7:0]  bytes_left;
  logic        string_list;
  logic [23:0] int_high;
  logic        type_fault;
  out_item_t   deframed_q[$];

  // 20 ns clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // The watchdog counts cycles and ends a run that hangs.
  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_wait(int max_wait);
    if (max_wait == 0 || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, max_wait);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one byte to the frame under construction.
  function automatic void add_frame_byte(logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  // Appends one result to the list of results still due.
  function automatic void expect_result(out_item_t r);
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic out_item_t make_result(kind_e kind, logic [31:0] val, status_e st,
                                            logic eos, logic ends);
    out_item_t r;
    r.result_kind   = kind;
    r.value         = val;
    r.status        = st;
    r.end_of_string = eos;
    r.ends_packet   = ends;
    return r;
  endfunction

  // Back to waiting for a length byte, as after reset and after every frame.
  function automatic void clear_parser();
    frame_phase   = PH_LEN;
    bytes_seen    = 8'd0;
    length_field  = 8'd0;
    string_list   = 1'b0;
    elements_left = 8'd0;
    bytes_left    = 8'd0;
    int_high      = 24'd0;
    type_fault    = 1'b0;
  endfunction

  // One list element is complete: the next one starts, or the list is over.
  function automatic void element_done();
    elements_left = elements_left - 8'd1;
    if (elements_left == 8'd0) frame_phase = PH_TAG;
    else frame_phase = PH_HEAD;
  endfunction

  // Advance the parser by one accepted byte and queue the results it causes:
  // at most its own result, then the closing status when the byte is the last.
  function automatic void deframe_byte(logic [7:0] b, logic lst);
    logic    mismatch;
    status_e st;
    case (frame_phase)
      PH_LEN: begin
        length_field = b;
        frame_phase  = PH_CMD;
      end
      PH_CMD: begin
        expect_result(make_result(KIND_CMD, {24'd0, b}, ST_OK, 1'b0, 1'b0));
        frame_phase = PH_TAG;
      end
      PH_TAG: frame_phase = PH_TYPE;
      PH_TYPE: begin
        string_list = (b == TYPE_STRING);
        type_fault  = (b > TYPE_STRING);
        frame_phase = PH_COUNT;
      end
      PH_COUNT: begin
        elements_left = b;
        // An empty list is skipped, even one of an unknown type.
        if (b == 8'd0) begin
          type_fault  = 1'b0;
          frame_phase = PH_TAG;
        end else if (type_fault) begin
          frame_phase = PH_SKIP;
        end else begin
          frame_phase = PH_HEAD;
        end
      end
      PH_HEAD: begin
        if (!string_list) begin
          int_high    = {16'd0, b};
          bytes_left  = 8'd3;
          frame_phase = PH_BODY;
        end else if (b == 8'd0) begin
          element_done();
        end else begin
          bytes_left  = b;
          frame_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (string_list) begin
          expect_result(make_result(KIND_CHAR, {24'd0, b}, ST_OK,
                                    bytes_left == 8'd1, 1'b0));
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) element_done();
        end else if (bytes_left > 8'd1) begin
          int_high   = {int_high[15:0], b};
          bytes_left = bytes_left - 8'd1;
        end else begin
          expect_result(make_result(KIND_INT, {int_high, b}, ST_OK, 1'b0, 1'b0));
          bytes_left = 8'd0;
          element_done();
        end
      end
      default: ;
    endcase

    if (lst) begin
      // A saturated byte count never matches, whatever the declared length.
      mismatch = (bytes_seen == POS_MAX) || ({1'b0, bytes_seen} + 9'd1 != {1'b0, length_field});
      if (mismatch) st = ST_LEN_MISMATCH;
      else if (frame_phase == PH_SKIP) st = ST_UNKNOWN_TYPE;
      else if (frame_phase != PH_TAG) st = ST_TRUNCATED;
      else st = ST_OK;
      expect_result(make_result(KIND_STATUS, 32'd0, st, 1'b0, 1'b1));
      clear_parser();
    end else if (bytes_seen != POS_MAX) begin
      bytes_seen = bytes_seen + 8'd1;
    end
  endfunction

  // Offer one byte after a random gap and hold it until the block takes it.
  // The caller always comes back in the step of the previous acceptance, so
  // valid and the payload get a single assignment in that step.
  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = draw_wait(tx_wait_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= '{data_byte: b, last: lst};
    do @(posedge clk); while (!in_ready);
    deframe_byte(b, lst);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  // A well-formed request with random content: up to three lists of integers,
  // strings or an unknown type. An unknown-type list with items is followed by
  // up to four junk bytes that the parser must ignore.
  task automatic build_request();
    int         lists;
    int         pick;
    int         count;
    int         len;
    logic [7:0] list_type;
    frame_bytes.delete();
    add_frame_byte(8'd0);
    add_frame_byte(rand_byte());
    lists = $urandom_range(0, 3);
    for (int l = 0; l < lists; l++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) list_type = TYPE_INTEGER;
      else if (pick < 8) list_type = TYPE_STRING;
      else list_type = 8'($urandom_range(TYPE_FIRST_UNKNOWN, TYPE_LAST_UNKNOWN));
      count = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
      if (list_type > TYPE_STRING && count != 0) count = $urandom_range(1, 255);
      add_frame_byte(rand_byte());
      add_frame_byte(list_type);
      add_frame_byte(8'(count));
      if (list_type > TYPE_STRING) begin
        if (count != 0) begin
          repeat ($urandom_range(0, 4)) add_frame_byte(rand_byte());
          break;
        end
      end else if (list_type == TYPE_INTEGER) begin
        repeat (4 * count) add_frame_byte(rand_byte());
      end else begin
        repeat (count) begin
          len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
          add_frame_byte(8'(len));
          repeat (len) add_frame_byte(rand_byte());
        end
      end
    end
    frame_bytes[0] = 8'(frame_bytes.size());
  endtask

  // One string list filled with strings so that the frame is total bytes long.
  task automatic build_long_frame(int total, logic [7:0] declared);
    int room;
    int n;
    frame_bytes.delete();
    add_frame_byte(declared);
    add_frame_byte(rand_byte());
    add_frame_byte(rand_byte());
    add_frame_byte(TYPE_STRING);
    add_frame_byte(8'd0);
    room = total - 5;
    while (room > 0) begin
      n = (room - 1 > 200) ? 200 : room - 1;
      add_frame_byte(8'(n));
      repeat (n) add_frame_byte(rand_byte());
      room = room - n - 1;
      frame_bytes[4] = frame_bytes[4] + 8'd1;
    end
  endtask

  // The receiver stalls a random number of cycles after each result, and for
  // a long stretch when hold_cycles asks for it. Its stall counter runs
  // whether or not a result is waiting, so stalls land on every phase.
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) stall_left = draw_wait(rx_wait_max);
      if (hold_cycles != 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Every accepted result is compared field by field with the oldest one due.
  initial begin : result_checker
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d value 0x%0h status %0d",
                   $time, out_item.result_kind, out_item.value, out_item.status);
          errors++;
        end else begin
          want = deframed_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_item.result_kind));
          check_field("value", want.value, out_item.value);
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("end_of_string", 32'(want.end_of_string), 32'(out_item.end_of_string));
          check_field("ends_packet", 32'(want.ends_packet), 32'(out_item.ends_packet));
          if (want.result_kind == KIND_STATUS) status_count[want.status]++;
          results_checked++;
        end
      end
    end
  end

  // Short frames that hit each closing status and the edges of the format.
  task automatic test_directed_frames();
    // A lone length byte: the command never comes, so the frame is truncated.
    frame_bytes = '{8'd1};
    send_frame();
    // Command 255 under a declared length one byte too long.
    frame_bytes = '{8'd3, 8'hFF};
    send_frame();
    // One integer list with the most negative value; the tag byte is all ones.
    frame_bytes = '{8'd9, 8'h00, 8'hFF, TYPE_INTEGER, 8'd1, 8'h80, 8'h00, 8'h00, 8'h00};
    send_frame();
    // An empty string, a one-character string, then an empty list of an
    // unknown type, which is skipped without error.
    frame_bytes = '{8'd11, 8'h41, 8'h00, TYPE_STRING, 8'd2, 8'd0, 8'd1, 8'h5A,
                    8'h10, TYPE_LAST_UNKNOWN, 8'd0};
    send_frame();
    // An unknown type with items: everything after the count is ignored.
    frame_bytes = '{8'd7, 8'h07, 8'h00, TYPE_FIRST_UNKNOWN, 8'd3, 8'hAA, 8'h55};
    send_frame();
  endtask

  // Frames around the point where the byte count saturates. Exactly 255 bytes
  // is fine. At 256 and 258 bytes the declared lengths 0 and 2 would match a
  // count that wraps instead of saturating, so both must report a mismatch.
  task automatic test_saturated_length();
    build_long_frame(255, 8'd255);
    send_frame();
    build_long_frame(256, 8'd0);
    send_frame();
    build_long_frame(258, 8'd2);
    send_frame();
  endtask

  // A stretch with neither side idling: one byte per cycle where possible.
  task automatic test_back_to_back();
    int stop_at;
    stop_at     = bytes_sent + 150;
    tx_wait_max = 0;
    rx_wait_max = 0;
    while (bytes_sent < stop_at) begin
      build_request();
      send_frame();
    end
    tx_wait_max = WAIT_MAX;
    rx_wait_max = WAIT_MAX;
  endtask

  // The receiver holds off for a long stretch while bytes keep coming, so the
  // result queue fills and the block has to stall its input.
  task automatic test_output_backpressure();
    int stop_at;
    stop_at     = bytes_sent + 60;
    tx_wait_max = 0;
    hold_cycles = HOLD_CYCLES;
    while (bytes_sent < stop_at) begin
      build_request();
      send_frame();
    end
    tx_wait_max = WAIT_MAX;
  endtask

  // Mostly well-formed requests, the rest broken: a wrong declared length,
  // a frame cut short, junk after the lists, or plain noise.
  task automatic test_random_frames();
    int stop_at;
    int pick;
    int cut;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      build_request();
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        frame_bytes[0] = rand_byte();
      end else if (pick < 4) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        if ($urandom_range(0, 1) == 1) frame_bytes[0] = 8'(cut);
      end else if (pick == 4) begin
        repeat ($urandom_range(1, 3)) add_frame_byte(rand_byte());
        if ($urandom_range(0, 1) == 1) frame_bytes[0] = 8'(frame_bytes.size());
      end else if (pick == 5) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) add_frame_byte(rand_byte());
        if ($urandom_range(0, 1) == 1) frame_bytes[0] = 8'(frame_bytes.size());
      end
      send_frame();
    end
  endtask

  // Reset once, run the tests in turn, drain, then report.
  initial begin
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_saturated_length();
    test_back_to_back();
    test_output_backpressure();
    test_random_frames();
    in_valid <= 1'b0;

    // Every byte is in; wait for the results still due, then a little longer
    // so that a stray extra result would show up.
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames in %0d bytes; checked %0d results over %0d cycles.",
             frames_sent, bytes_sent, results_checked, cycles_run);
    $display("Frames closed: %0d ok, %0d length mismatch, %0d truncated, %0d unknown type.",
             status_count[ST_OK], status_count[ST_LEN_MISMATCH],
             status_count[ST_TRUNCATED], status_count[ST_UNKNOWN_TYPE]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rpd_pkg.sv
design/rpd_parser.sv
design/rpd_out_queue.sv
design/request_packet_deframer.sv
verif/request_packet_deframer_tb.sv
